// File: src/rmq_pkg.sv
`timescale 1ns / 1ps
// rmq_pkg: shared constants and types for the rotation matrix to quaternion block
// no dependencies

package rmq_pkg;

    localparam int DATA_W        = 16;
    localparam int NLANE         = 4;
    localparam int FRAC_BITS_DEF = 15;

    // what to do with a magnitude at the output
    localparam logic [1:0] SGN_POS  = 2'd0;
    localparam logic [1:0] SGN_NEG  = 2'd1;
    localparam logic [1:0] SGN_ZERO = 2'd2;

    typedef struct packed {
        logic       sat;
        logic [1:0] sgn;
    } lane_ctl_t;

endpackage

// File: src/rmq_pre.sv
`timescale 1ns / 1ps
// rmq_pre: radicand sums, absolute values, saturation and sign decisions
// depends on rmq_pkg

module rmq_pre #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r11,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r12,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r13,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r21,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r22,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r23,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r31,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r32,
    input  logic signed [rmq_pkg::DATA_W-1:0]    r33,
    output logic                                 valid_out,
    output logic [2*((FRAC_BITS < 15) ? FRAC_BITS : 15)-1:0] rad_out [rmq_pkg::NLANE],
    output rmq_pkg::lane_ctl_t                   ctl_out [rmq_pkg::NLANE]
);
    import rmq_pkg::*;

    localparam int LB   = (FRAC_BITS < 15) ? FRAC_BITS : 15;
    localparam int RADW = 2 * LB;
    localparam int SW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    // sqrt(A << (F-2)) >= 2^LB exactly when A >= 2^AK
    localparam int AK   = 2 * LB - FRAC_BITS + 2;
    localparam int DW   = DATA_W + 1;

    logic signed [SW-1:0] one;
    logic signed [SW-1:0] a11, a22, a33;
    logic signed [SW-1:0] sum [NLANE];
    logic        [SW-1:0] mag [NLANE];
    logic signed [DW-1:0] diff [NLANE];

    logic                 valid_reg;
    logic [RADW-1:0]      rad_reg  [NLANE];
    logic [RADW-1:0]      rad_next [NLANE];
    lane_ctl_t            ctl_reg  [NLANE];
    lane_ctl_t            ctl_next [NLANE];

    assign one = SW'(1) << FRAC_BITS;
    assign a11 = {{(SW-DATA_W){r11[DATA_W-1]}}, r11};
    assign a22 = {{(SW-DATA_W){r22[DATA_W-1]}}, r22};
    assign a33 = {{(SW-DATA_W){r33[DATA_W-1]}}, r33};

    assign sum[0] = one + a11 + a22 + a33;
    assign sum[1] = one + a11 - a22 - a33;
    assign sum[2] = one - a11 + a22 - a33;
    assign sum[3] = one - a11 - a22 + a33;

    assign diff[0] = '0;
    assign diff[1] = {r32[DATA_W-1], r32} - {r23[DATA_W-1], r23};
    assign diff[2] = {r13[DATA_W-1], r13} - {r31[DATA_W-1], r31};
    assign diff[3] = {r21[DATA_W-1], r21} - {r12[DATA_W-1], r12};

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            mag[i] = sum[i][SW-1] ? SW'(-sum[i]) : sum[i];
            rad_next[i] = {mag[i][AK-1:0], {(FRAC_BITS-2){1'b0}}};
            ctl_next[i].sat = |mag[i][SW-1:AK];
            if (i == 0) begin
                ctl_next[i].sgn = SGN_POS;
            end else if (diff[i] == '0) begin
                ctl_next[i].sgn = SGN_ZERO;
            end else if (diff[i][DW-1]) begin
                ctl_next[i].sgn = SGN_POS;
            end else begin
                ctl_next[i].sgn = SGN_NEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= rad_next;
            ctl_reg <= ctl_next;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign ctl_out   = ctl_reg;

endmodule

// File: src/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
// rmq_sqrt_cell: one restoring square root step, one root bit for each of the lanes
// depends on rmq_pkg

module rmq_sqrt_cell #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [2*((FRAC_BITS < 15) ? FRAC_BITS : 15)-1:0] rad_in [rmq_pkg::NLANE],
    input  logic [((FRAC_BITS < 15) ? FRAC_BITS : 15)+2:0]   rem_in [rmq_pkg::NLANE],
    input  logic [((FRAC_BITS < 15) ? FRAC_BITS : 15)-1:0]   root_in [rmq_pkg::NLANE],
    input  rmq_pkg::lane_ctl_t   ctl_in [rmq_pkg::NLANE],
    output logic                 valid_out,
    output logic [2*((FRAC_BITS < 15) ? FRAC_BITS : 15)-1:0] rad_out [rmq_pkg::NLANE],
    output logic [((FRAC_BITS < 15) ? FRAC_BITS : 15)+2:0]   rem_out [rmq_pkg::NLANE],
    output logic [((FRAC_BITS < 15) ? FRAC_BITS : 15)-1:0]   root_out [rmq_pkg::NLANE],
    output rmq_pkg::lane_ctl_t   ctl_out [rmq_pkg::NLANE]
);
    import rmq_pkg::*;

    localparam int LB   = (FRAC_BITS < 15) ? FRAC_BITS : 15;
    localparam int RADW = 2 * LB;
    localparam int RW   = LB + 3;

    logic [RW-1:0]   rem_sh [NLANE];
    logic [RW-1:0]   trial  [NLANE];

    logic            valid_reg;
    logic [RADW-1:0] rad_reg   [NLANE];
    logic [RADW-1:0] rad_next  [NLANE];
    logic [RW-1:0]   rem_reg   [NLANE];
    logic [RW-1:0]   rem_next  [NLANE];
    logic [LB-1:0]   root_reg  [NLANE];
    logic [LB-1:0]   root_next [NLANE];
    lane_ctl_t       ctl_reg   [NLANE];

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            // bring down the next two radicand bits
            rem_sh[i]   = {rem_in[i][RW-3:0], rad_in[i][RADW-1:RADW-2]};
            trial[i]    = {1'b0, root_in[i], 2'b01};
            rad_next[i] = {rad_in[i][RADW-3:0], 2'b00};
            if (rem_sh[i] >= trial[i]) begin
                rem_next[i]  = rem_sh[i] - trial[i];
                root_next[i] = {root_in[i][LB-2:0], 1'b1};
            end else begin
                rem_next[i]  = rem_sh[i];
                root_next[i] = {root_in[i][LB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            ctl_reg  <= ctl_in;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign ctl_out   = ctl_reg;

endmodule

// File: src/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Path from input beat to result: a register for the radicand sums, one square root cell
// per root bit in the chain, and the sign and saturation output register.
// Throughput: one matrix per cycle; the whole pipeline holds only while a result waits.
// Reset (aresetn low, synchronous) clears the valid bits of all stages.
// Depends on rmq_pkg, rmq_pre, rmq_sqrt_cell.

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r11,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r12,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r13,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r21,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r22,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r23,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r31,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r32,
    input  logic signed [rmq_pkg::DATA_W-1:0] s_r33,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rmq_pkg::DATA_W-1:0] m_quat_w,
    output logic signed [rmq_pkg::DATA_W-1:0] m_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0] m_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0] m_quat_z
);
    import rmq_pkg::*;

    localparam int LB   = (FRAC_BITS < 15) ? FRAC_BITS : 15;
    localparam int RADW = 2 * LB;
    localparam int RW   = LB + 3;

    logic            en;
    logic            valid_w [LB+1];
    logic [RADW-1:0] rad_w   [LB+1][NLANE];
    logic [RW-1:0]   rem_w   [LB+1][NLANE];
    logic [LB-1:0]   root_w  [LB+1][NLANE];
    lane_ctl_t       ctl_w   [LB+1][NLANE];

    logic              out_valid_reg;
    logic [DATA_W-1:0] quat_reg  [NLANE];
    logic [DATA_W-1:0] quat_next [NLANE];
    logic [LB-1:0]     mag       [NLANE];
    logic [DATA_W-1:0] mag16     [NLANE];

    // every stage moves together unless the result register is full and not taken
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    rmq_pre #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .r11       (s_r11),
        .r12       (s_r12),
        .r13       (s_r13),
        .r21       (s_r21),
        .r22       (s_r22),
        .r23       (s_r23),
        .r31       (s_r31),
        .r32       (s_r32),
        .r33       (s_r33),
        .valid_out (valid_w[0]),
        .rad_out   (rad_w[0]),
        .ctl_out   (ctl_w[0])
    );

    for (genvar i = 0; i < NLANE; i++) begin : g_seed
        assign rem_w[0][i]  = '0;
        assign root_w[0][i] = '0;
    end

    for (genvar k = 0; k < LB; k++) begin : g_cell
        rmq_sqrt_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_w[k]),
            .rad_in    (rad_w[k]),
            .rem_in    (rem_w[k]),
            .root_in   (root_w[k]),
            .ctl_in    (ctl_w[k]),
            .valid_out (valid_w[k+1]),
            .rad_out   (rad_w[k+1]),
            .rem_out   (rem_w[k+1]),
            .root_out  (root_w[k+1]),
            .ctl_out   (ctl_w[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            mag[i]   = ctl_w[LB][i].sat ? {LB{1'b1}} : root_w[LB][i];
            mag16[i] = {{(DATA_W-LB){1'b0}}, mag[i]};
            case (ctl_w[LB][i].sgn)
                SGN_POS:  quat_next[i] = mag16[i];
                SGN_NEG:  quat_next[i] = DATA_W'(-mag16[i]);
                default:  quat_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_w[LB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg <= quat_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_quat_w = quat_reg[0];
    assign m_quat_x = quat_reg[1];
    assign m_quat_y = quat_reg[2];
    assign m_quat_z = quat_reg[3];

endmodule
